>>> src/arcm_pkg.sv
// Shared types and constants for the ADC RMS current meter.
`timescale 1ns / 1ps

package arcm_pkg;

  // Fixed field widths
  localparam int OFFSET_BITS  = 10;
  localparam int WINDOW_BITS  = 10;
  localparam int DIVISOR_BITS = 11;
  localparam int CGAIN_BITS   = 16;
  localparam int PGAIN_BITS   = 8;
  localparam int SUM_BITS     = 28;
  localparam int RMS_BITS     = 16;
  localparam int POWER_BITS   = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_DIVISOR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_GAIN    = 3'd4;

  // Reset values
  localparam logic [OFFSET_BITS-1:0]  RST_CENTER_OFFSET = 10'd512;
  localparam logic [WINDOW_BITS-1:0]  RST_WINDOW_LENGTH = 10'd200;
  localparam logic [DIVISOR_BITS-1:0] RST_MEAN_DIVISOR  = 11'd201;
  localparam logic [CGAIN_BITS-1:0]   RST_CURRENT_GAIN  = 16'd865;
  localparam logic [PGAIN_BITS-1:0]   RST_POWER_GAIN    = 8'd128;

  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
  localparam logic [RMS_BITS-1:0] RMS_MAX = {RMS_BITS{1'b1}};

  typedef struct packed {
    logic [OFFSET_BITS-1:0]  center_offset;
    logic [WINDOW_BITS-1:0]  window_length;
    logic [DIVISOR_BITS-1:0] mean_divisor;
    logic [CGAIN_BITS-1:0]   current_gain;
    logic [PGAIN_BITS-1:0]   power_gain;
  } cfg_t;

endpackage

>>> src/arcm_front.sv
// Sample front end: offset removal, squaring, window accumulation.
`timescale 1ns / 1ps

module arcm_front #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        in_adc_sample,
  input  arcm_pkg::cfg_t                cfg,
  input  logic                          space_ok,
  output logic                          push_valid,
  output logic [arcm_pkg::SUM_BITS-1:0] push_sum
);
  import arcm_pkg::*;

  localparam int OFF_W = (SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS;
  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int ACC_W = ((SQ_W > SUM_BITS) ? SQ_W : SUM_BITS) + 1;

  logic [OFF_W-1:0]       off_wide;
  logic [SAMPLE_BITS-1:0] center;
  logic                   accept;
  logic [SAMPLE_BITS-1:0] diff_nxt;

  logic                   s1_v_r;
  logic [SAMPLE_BITS-1:0] diff_r;
  logic                   s2_v_r;
  logic [SQ_W-1:0]        sq_r;

  logic [SUM_BITS-1:0]    sum_r;
  logic [WINDOW_BITS-1:0] cnt_r;
  logic [ACC_W-1:0]       acc_wide;
  logic [SUM_BITS-1:0]    sum_nxt;
  logic [WINDOW_BITS-1:0] cnt_nxt;
  logic [WINDOW_BITS-1:0] win_len;
  logic                   win_end;

  // Accept only while the queue can take every transaction in flight
  assign in_ready = space_ok;
  assign accept   = in_valid && in_ready;

  // Offset is masked to the sample width
  assign off_wide = OFF_W'(cfg.center_offset);
  assign center   = off_wide[SAMPLE_BITS-1:0];
  assign diff_nxt = (in_adc_sample >= center) ? (in_adc_sample - center)
                                              : (center - in_adc_sample);

  // Stage 1: absolute difference
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
    if (accept) begin
      diff_r <= diff_nxt;
    end
  end

  // Stage 2: square
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    if (s1_v_r) begin
      sq_r <= SQ_W'(diff_r) * SQ_W'(diff_r);
    end
  end

  // Stage 3: saturating accumulate and window check
  assign acc_wide = ACC_W'(sum_r) + ACC_W'(sq_r);
  assign sum_nxt  = (acc_wide > ACC_W'(SUM_MAX)) ? SUM_MAX : acc_wide[SUM_BITS-1:0];
  assign cnt_nxt  = cnt_r + 1'b1;
  assign win_len  = (cfg.window_length == '0) ? WINDOW_BITS'(1) : cfg.window_length;
  assign win_end  = s2_v_r && (cnt_nxt >= win_len);

  assign push_valid = win_end;
  assign push_sum   = sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (s2_v_r) begin
      if (win_end) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

>>> src/arcm_queue.sv
// Small register FIFO between the front end and the back end.
`timescale 1ns / 1ps

module arcm_queue #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       pop_valid,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign count     = count_r;
  assign do_pop    = pop && pop_valid;

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> src/arcm_back.sv
// Window back end: divide, square root, gain scaling and result register.
`timescale 1ns / 1ps

module arcm_back #(
  parameter int ROOT_FRACTION_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pop_valid,
  output logic                            pop,
  input  logic [arcm_pkg::SUM_BITS-1:0]   pop_sum,
  input  arcm_pkg::cfg_t                  cfg,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [arcm_pkg::RMS_BITS-1:0]   out_rms_current,
  output logic [arcm_pkg::POWER_BITS-1:0] out_power_estimate
);
  import arcm_pkg::*;

  localparam int DW    = SUM_BITS + 2 * ROOT_FRACTION_BITS;  // dividend width
  localparam int RW    = DW / 2;                             // root width
  localparam int REM_W = DIVISOR_BITS + 1;
  localparam int PW    = RW + CGAIN_BITS;
  localparam int CNT_W = $clog2(DW + 1);
  localparam int SHIFT = ROOT_FRACTION_BITS + 6;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_RMS  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]              state_r;
  logic [CNT_W-1:0]        step_r;
  logic [DW-1:0]           quo_r;
  logic [REM_W-1:0]        rem_r;
  logic [DW-1:0]           val_r;
  logic [DW-1:0]           res_r;
  logic [DW-1:0]           bit_r;
  logic [PW-1:0]           prod_r;
  logic [RMS_BITS-1:0]     rms_r;
  logic                    out_valid_r;
  logic [RMS_BITS-1:0]     out_rms_r;
  logic [POWER_BITS-1:0]   out_pwr_r;

  logic [DIVISOR_BITS-1:0] divisor;
  logic [REM_W-1:0]        rem_sh;
  logic                    rem_ge;
  logic [DW-1:0]           trial;
  logic                    root_ge;
  logic [PW-1:0]           prod_sh;
  logic                    out_free;

  assign pop                = (state_r == ST_IDLE) && pop_valid;
  assign out_valid          = out_valid_r;
  assign out_rms_current    = out_rms_r;
  assign out_power_estimate = out_pwr_r;
  assign out_free           = !out_valid_r || out_ready;

  // Restoring divide step, one quotient bit per cycle
  assign divisor = (cfg.mean_divisor == '0) ? DIVISOR_BITS'(1) : cfg.mean_divisor;
  assign rem_sh  = {rem_r[REM_W-2:0], quo_r[DW-1]};
  assign rem_ge  = (rem_sh >= REM_W'(divisor));

  // Square root step, one result bit per cycle
  assign trial   = res_r + bit_r;
  assign root_ge = (val_r >= trial);

  // Gain product scaled down to Q10 amps
  assign prod_sh = prod_r >> SHIFT;

  // Raise on a finished window, drop once the transaction is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_FIN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Sequence one window result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (pop_valid) begin
            quo_r   <= DW'(pop_sum) << (2 * ROOT_FRACTION_BITS);
            rem_r   <= '0;
            step_r  <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r  <= rem_ge ? (rem_sh - REM_W'(divisor)) : rem_sh;
          quo_r  <= {quo_r[DW-2:0], rem_ge};
          if (step_r == CNT_W'(DW - 1)) begin
            step_r  <= '0;
            state_r <= ST_ROOT;
            val_r   <= {quo_r[DW-2:0], rem_ge};
            res_r   <= '0;
            bit_r   <= DW'(1) << (DW - 2);
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_ROOT: begin
          if (root_ge) begin
            val_r <= val_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r  <= bit_r >> 2;
          step_r <= step_r + 1'b1;
          if (step_r == CNT_W'(RW - 1)) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= PW'(res_r[RW-1:0]) * PW'(cfg.current_gain);
          state_r <= ST_RMS;
        end
        ST_RMS: begin
          rms_r   <= (prod_sh > PW'(RMS_MAX)) ? RMS_MAX : prod_sh[RMS_BITS-1:0];
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          // Hold until the result register is free
          if (out_free) begin
            out_rms_r   <= rms_r;
            out_pwr_r   <= POWER_BITS'(rms_r) * POWER_BITS'(cfg.power_gain);
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/adc_rms_current_meter.sv
// Path: a window's last sample passes the difference and square registers into
//   the queue, then the back end divides, takes the square root and scales the gain.
// Throughput: one sample per cycle while the result queue has room; the back end
//   takes a new window from the queue only once it has finished the last one.
// Reset: synchronous, active low; registers return to their defaults and the
//   running sum, sample count, queue and result valid flag clear.
`timescale 1ns / 1ps

module adc_rms_current_meter #(
  parameter int SAMPLE_BITS        = 10,
  parameter int ROOT_FRACTION_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [SAMPLE_BITS-1:0]            in_adc_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [arcm_pkg::RMS_BITS-1:0]     out_rms_current,
  output logic [arcm_pkg::POWER_BITS-1:0]   out_power_estimate,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [arcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [arcm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import arcm_pkg::*;

  localparam int Q_DEPTH = 4;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  cfg_t                cfg_r;
  logic                push_valid;
  logic [SUM_BITS-1:0] push_sum;
  logic                pop_valid;
  logic                pop;
  logic [SUM_BITS-1:0] pop_sum;
  logic [Q_CNT_W-1:0]  q_count;
  logic                space_ok;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_offset <= RST_CENTER_OFFSET;
      cfg_r.window_length <= RST_WINDOW_LENGTH;
      cfg_r.mean_divisor  <= RST_MEAN_DIVISOR;
      cfg_r.current_gain  <= RST_CURRENT_GAIN;
      cfg_r.power_gain    <= RST_POWER_GAIN;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_OFFSET: cfg_r.center_offset <= cfg_data[OFFSET_BITS-1:0];
        REG_WINDOW_LENGTH: cfg_r.window_length <= cfg_data[WINDOW_BITS-1:0];
        REG_MEAN_DIVISOR:  cfg_r.mean_divisor  <= cfg_data[DIVISOR_BITS-1:0];
        REG_CURRENT_GAIN:  cfg_r.current_gain  <= cfg_data[CGAIN_BITS-1:0];
        REG_POWER_GAIN:    cfg_r.power_gain    <= cfg_data[PGAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Room for the new sample plus the two still in the front pipeline
  assign space_ok = (q_count <= Q_CNT_W'(Q_DEPTH - 3));

  arcm_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_adc_sample (in_adc_sample),
    .cfg           (cfg_r),
    .space_ok      (space_ok),
    .push_valid    (push_valid),
    .push_sum      (push_sum)
  );

  arcm_queue #(
    .WIDTH (SUM_BITS),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_sum),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_data  (pop_sum),
    .count     (q_count)
  );

  arcm_back #(
    .ROOT_FRACTION_BITS (ROOT_FRACTION_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop                (pop),
    .pop_sum            (pop_sum),
    .cfg                (cfg_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_rms_current    (out_rms_current),
    .out_power_estimate (out_power_estimate)
  );

endmodule

>>> tb/sv/adc_rms_current_meter_tb.sv
// Self-checking testbench for the ADC RMS current meter: directed and random windows.
`timescale 1ns / 1ps

module adc_rms_current_meter_tb;
  import arcm_pkg::*;

  localparam int SAMPLE_BITS        = 10;
  localparam int ROOT_FRACTION_BITS = 10;
  localparam int SETTLE_CYCLES      = 120;
  localparam int HOLD_CYCLES        = 400;
  localparam int DIRECTED_ITEMS     = 20;
  localparam int RANDOM_ITEMS       = 1330;
  localparam int CYCLE_LIMIT        = 1000000;
  localparam int MAX_PRINTED        = 40;
  localparam longint unsigned POWER_MAX = (64'd1 << POWER_BITS) - 1;
  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

  typedef enum logic [1:0] {OP_SAMPLE, OP_CFG, OP_MODE, OP_HOLD} stim_kind_t;

  typedef struct {
    stim_kind_t             kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  value;
    int                     send_pct;
    int                     recv_pct;
  } stim_op_t;

  typedef struct {
    logic [RMS_BITS-1:0]   rms;
    logic [POWER_BITS-1:0] power;
  } meter_reading_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [SAMPLE_BITS-1:0]  in_adc_sample = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [RMS_BITS-1:0]     out_rms_current;
  logic [POWER_BITS-1:0]   out_power_estimate;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // Predictor copy of the registers and the window state
  logic [OFFSET_BITS-1:0]  meter_center;
  logic [WINDOW_BITS-1:0]  meter_window;
  logic [DIVISOR_BITS-1:0] meter_divisor;
  logic [CGAIN_BITS-1:0]   meter_cgain;
  logic [PGAIN_BITS-1:0]   meter_pgain;
  logic [SUM_BITS-1:0]     meter_sum;
  logic [WINDOW_BITS-1:0]  meter_count;

  stim_op_t        op_queue[$];
  meter_reading_t  expected_readings[$];
  meter_reading_t  exp_rd;
  stim_op_t        drv_op;

  logic nxt_in_valid, nxt_cfg_valid, nxt_hold_req;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   settle_count = 0;
  int   cycle_count = 0;
  int   plan_center = 512;
  int   planned_samples = 0;
  int   samples_taken = 0;
  int   cfg_writes = 0;
  int   windows_checked = 0;
  int   error_count = 0;

  adc_rms_current_meter #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .ROOT_FRACTION_BITS(ROOT_FRACTION_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_adc_sample     (in_adc_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_rms_current   (out_rms_current),
    .out_power_estimate(out_power_estimate),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Floor square root, one result bit per pass from the top
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  function automatic void meter_reset();
    meter_center  = RST_CENTER_OFFSET;
    meter_window  = RST_WINDOW_LENGTH;
    meter_divisor = RST_MEAN_DIVISOR;
    meter_cgain   = RST_CURRENT_GAIN;
    meter_pgain   = RST_POWER_GAIN;
    meter_sum     = '0;
    meter_count   = '0;
  endfunction

  function automatic void meter_write_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CENTER_OFFSET: meter_center  = data[OFFSET_BITS-1:0];
      REG_WINDOW_LENGTH: meter_window  = data[WINDOW_BITS-1:0];
      REG_MEAN_DIVISOR:  meter_divisor = data[DIVISOR_BITS-1:0];
      REG_CURRENT_GAIN:  meter_cgain   = data[CGAIN_BITS-1:0];
      REG_POWER_GAIN:    meter_pgain   = data[PGAIN_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Accumulate one sample; close the window and queue the reading when full
  function automatic void meter_take_sample(input logic [SAMPLE_BITS-1:0] s);
    longint unsigned diff, sum64, win, div, quot, root, rms_w, pwr_w;
    meter_reading_t  rd;
    diff  = (s >= meter_center) ? longint'(s - meter_center) : longint'(meter_center - s);
    sum64 = longint'(meter_sum) + diff * diff;
    if (sum64 > longint'(SUM_MAX)) sum64 = longint'(SUM_MAX);
    meter_count = meter_count + 1'b1;
    win = (meter_window == 0) ? 1 : longint'(meter_window);
    if (longint'(meter_count) >= win) begin
      div   = (meter_divisor == 0) ? 1 : longint'(meter_divisor);
      quot  = (sum64 << (2 * ROOT_FRACTION_BITS)) / div;
      root  = floor_sqrt(quot);
      rms_w = (root * longint'(meter_cgain)) >> (ROOT_FRACTION_BITS + 6);
      if (rms_w > longint'(RMS_MAX)) rms_w = longint'(RMS_MAX);
      pwr_w = rms_w * longint'(meter_pgain);
      if (pwr_w > POWER_MAX) pwr_w = POWER_MAX;
      rd.rms   = rms_w[RMS_BITS-1:0];
      rd.power = pwr_w[POWER_BITS-1:0];
      expected_readings.push_back(rd);
      meter_sum   = '0;
      meter_count = '0;
    end else begin
      meter_sum = sum64[SUM_BITS-1:0];
    end
  endfunction

  // Stimulus plan builders; unused upper data bits of register writes get random garbage
  function automatic void queue_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input int unsigned value, input int width);
    stim_op_t    op;
    int unsigned mask;
    mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 1);
    op.kind     = OP_CFG;
    op.idx      = idx;
    op.value    = CFG_DATA_W'(($urandom & ~mask) | (value & mask));
    op.send_pct = 0;
    op.recv_pct = 0;
    if (idx == REG_CENTER_OFFSET) plan_center = int'(value & mask);
    op_queue.push_back(op);
  endfunction

  function automatic void queue_sample(input int unsigned value);
    stim_op_t op;
    op.kind     = OP_SAMPLE;
    op.idx      = '0;
    op.value    = CFG_DATA_W'(value);
    op.send_pct = 0;
    op.recv_pct = 0;
    op_queue.push_back(op);
    planned_samples++;
  endfunction

  function automatic void queue_ctrl(input stim_kind_t kind, input int send_pct,
                                     input int recv_pct);
    stim_op_t op;
    op.kind     = kind;
    op.idx      = '0;
    op.value    = '0;
    op.send_pct = send_pct;
    op.recv_pct = recv_pct;
    op_queue.push_back(op);
  endfunction

  function automatic int unsigned pick_extreme(input int unsigned top);
    return $urandom_range(1) ? top : 0;
  endfunction

  function automatic int unsigned random_sample();
    int unsigned r;
    int          near;
    r = $urandom_range(99);
    if (r < 20) return pick_extreme(1023);
    if (r < 45) begin
      near = plan_center + int'($urandom_range(16)) - 8;
      if (near < 0) near = 0;
      if (near > 1023) near = 1023;
      return near;
    end
    return $urandom_range(1023);
  endfunction

  // New settings for every register, then a burst of samples
  function automatic void queue_random_phase();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    queue_cfg(REG_CENTER_OFFSET, (r < 20) ? pick_extreme(1023) : $urandom_range(1023),
              OFFSET_BITS);
    r = $urandom_range(99);
    if (r < 55)      queue_cfg(REG_WINDOW_LENGTH, $urandom_range(1, 8), WINDOW_BITS);
    else if (r < 80) queue_cfg(REG_WINDOW_LENGTH, $urandom_range(9, 40), WINDOW_BITS);
    else if (r < 90) queue_cfg(REG_WINDOW_LENGTH, pick_extreme(1023), WINDOW_BITS);
    else             queue_cfg(REG_WINDOW_LENGTH, $urandom_range(41, 1023), WINDOW_BITS);
    r = $urandom_range(99);
    if (r < 15)      queue_cfg(REG_MEAN_DIVISOR, pick_extreme(1), DIVISOR_BITS);
    else if (r < 30) queue_cfg(REG_MEAN_DIVISOR, $urandom_range(1) ? 1024 : 2047,
                               DIVISOR_BITS);
    else if (r < 40) queue_cfg(REG_MEAN_DIVISOR, $urandom_range(2047), DIVISOR_BITS);
    else             queue_cfg(REG_MEAN_DIVISOR, $urandom_range(1, 1024), DIVISOR_BITS);
    r = $urandom_range(99);
    queue_cfg(REG_CURRENT_GAIN, (r < 15) ? pick_extreme(65535) : $urandom_range(65535),
              CGAIN_BITS);
    r = $urandom_range(99);
    queue_cfg(REG_POWER_GAIN, (r < 15) ? pick_extreme(255) : $urandom_range(255),
              PGAIN_BITS);
    n = $urandom_range(10, 50);
    repeat (n) queue_sample(random_sample());
  endfunction

  // Driver: sample and register transactions from the plan
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      cfg_valid    <= 1'b0;
      hold_req     <= 1'b0;
      settle_count <= 0;
      meter_reset();
    end else begin
      if (in_valid && in_ready) begin
        meter_take_sample(in_adc_sample);
        samples_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        meter_write_reg(cfg_index, cfg_data);
        cfg_writes++;
      end
      // Count quiet cycles so a write never lands on a sample still in flight
      if (in_valid || expected_readings.size() != 0) settle_count <= 0;
      else if (settle_count < SETTLE_CYCLES) settle_count <= settle_count + 1;

      nxt_in_valid  = in_valid && !in_ready;
      nxt_cfg_valid = cfg_valid && !cfg_ready;
      nxt_hold_req  = 1'b0;
      if (!nxt_in_valid && !nxt_cfg_valid && op_queue.size() != 0) begin
        case (op_queue[0].kind)
          OP_SAMPLE: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              drv_op        = op_queue.pop_front();
              nxt_in_valid  = 1'b1;
              in_adc_sample <= drv_op.value[SAMPLE_BITS-1:0];
            end
          end
          OP_CFG: begin
            if (!in_valid && settle_count >= SETTLE_CYCLES) begin
              drv_op        = op_queue.pop_front();
              nxt_cfg_valid = 1'b1;
              cfg_index     <= drv_op.idx;
              cfg_data      <= drv_op.value;
            end
          end
          OP_MODE: begin
            drv_op        = op_queue.pop_front();
            send_idle_pct <= drv_op.send_pct;
            recv_idle_pct <= drv_op.recv_pct;
          end
          default: begin
            drv_op       = op_queue.pop_front();
            nxt_hold_req = 1'b1;
          end
        endcase
      end
      in_valid  <= nxt_in_valid;
      cfg_valid <= nxt_cfg_valid;
      hold_req  <= nxt_hold_req;
    end
  end

  // Receiver: random back-pressure, plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result transaction with the oldest predicted reading
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected result rms=%0d power=%0d",
                                  out_rms_current, out_power_estimate));
      end else begin
        exp_rd = expected_readings.pop_front();
        if (out_rms_current !== exp_rd.rms)
          report_mismatch($sformatf("rms_current got %0d expected %0d",
                                    out_rms_current, exp_rd.rms));
        if (out_power_estimate !== exp_rd.power)
          report_mismatch($sformatf("power_estimate got %0d expected %0d",
                                    out_power_estimate, exp_rd.power));
        windows_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    // Directed: one-sample windows at the field extremes
    queue_ctrl(OP_MODE, 0, 0);
    queue_cfg(REG_WINDOW_LENGTH, 1, WINDOW_BITS);
    queue_cfg(REG_MEAN_DIVISOR, 1, DIVISOR_BITS);
    queue_cfg(REG_CURRENT_GAIN, 65535, CGAIN_BITS);
    queue_cfg(REG_POWER_GAIN, 255, PGAIN_BITS);
    queue_cfg(REG_CENTER_OFFSET, 0, OFFSET_BITS);
    queue_sample(0);
    queue_sample(1023);
    queue_sample(1);
    queue_cfg(REG_CENTER_OFFSET, 1023, OFFSET_BITS);
    queue_sample(0);
    queue_sample(1023);
    queue_sample(1022);
    // Zero current gain
    queue_cfg(REG_CENTER_OFFSET, 512, OFFSET_BITS);
    queue_cfg(REG_CURRENT_GAIN, 0, CGAIN_BITS);
    queue_sample(0);
    queue_sample(1023);
    // Zero window length and zero divisor both act as one
    queue_cfg(REG_WINDOW_LENGTH, 0, WINDOW_BITS);
    queue_cfg(REG_MEAN_DIVISOR, 0, DIVISOR_BITS);
    queue_cfg(REG_CURRENT_GAIN, 865, CGAIN_BITS);
    queue_cfg(REG_POWER_GAIN, 0, PGAIN_BITS);
    queue_sample(100);
    queue_sample(900);
    // Divisor above 1024, write to an index with no register
    queue_cfg(REG_WINDOW_LENGTH, 4, WINDOW_BITS);
    queue_cfg(REG_MEAN_DIVISOR, 2047, DIVISOR_BITS);
    queue_cfg(REG_POWER_GAIN, 128, PGAIN_BITS);
    queue_cfg(REG_SPARE, 16'hFFFF, CFG_DATA_W);
    queue_sample(0);
    queue_sample(1023);
    queue_sample(0);
    queue_sample(1023);
    // Window shortened below the running count closes on the next sample
    queue_cfg(REG_WINDOW_LENGTH, 10, WINDOW_BITS);
    queue_sample(300);
    queue_sample(700);
    queue_sample(512);
    queue_sample(513);
    queue_sample(1000);
    queue_cfg(REG_WINDOW_LENGTH, 3, WINDOW_BITS);
    queue_sample(0);

    // Random, sender idles lightly and receiver heavily
    queue_ctrl(OP_MODE, 29, 67);
    while (planned_samples < DIRECTED_ITEMS + RANDOM_ITEMS / 3) queue_random_phase();

    // Roles swapped; start with a window long enough to saturate the sum
    queue_ctrl(OP_MODE, 67, 29);
    queue_cfg(REG_WINDOW_LENGTH, 1, WINDOW_BITS);
    queue_sample(random_sample());
    queue_cfg(REG_CENTER_OFFSET, 0, OFFSET_BITS);
    queue_cfg(REG_WINDOW_LENGTH, 300, WINDOW_BITS);
    queue_cfg(REG_MEAN_DIVISOR, $urandom_range(1, 1024), DIVISOR_BITS);
    queue_cfg(REG_CURRENT_GAIN, $urandom_range(65535), CGAIN_BITS);
    repeat (300) queue_sample($urandom_range(1000, 1023));
    while (planned_samples < DIRECTED_ITEMS + 2 * RANDOM_ITEMS / 3) queue_random_phase();

    // No idling; a long receiver hold first so the block backs up
    queue_ctrl(OP_MODE, 0, 0);
    queue_cfg(REG_WINDOW_LENGTH, 1, WINDOW_BITS);
    queue_ctrl(OP_HOLD, 0, 0);
    repeat (80) queue_sample(random_sample());
    while (planned_samples < DIRECTED_ITEMS + RANDOM_ITEMS) queue_random_phase();

    // Wait for the plan to drain and every reading to come back
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (op_queue.size() != 0 || in_valid || cfg_valid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d samples and %0d register writes, incl. saturation and long hold",
             samples_taken, cfg_writes);
    $display("checked %0d window readings, %0d mismatches", windows_checked, error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
